>>> hdl/bmpm_pkg.sv
// Shared types and constants for the binary multi-pattern matcher.
package bmpm_pkg;
  localparam int unsigned PAT_W = 32;
  localparam int unsigned LEN_W = 6;
  localparam int unsigned ID_W = 7;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_BIT  = 2'd1,
    OP_END  = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  // Classified command handed from the front end to the back end.
  typedef struct packed {
    op_t              op;
    logic [PAT_W-1:0] value;
    logic             lookup;
  } cmd_t;
endpackage

>>> hdl/binary_multi_pattern_matcher_unit.sv
// Top level of the binary multi-pattern matcher.
// Flow: a transaction passes through the queue; the back end finishes a bit with no lookup,
//   an ignored load or an unused opcode in its idle state, steps a load or a lookup through
//   read and check states once per probe, and sweeps every flag at end of text.
// The back end takes a new transaction only in its idle state, so the hash probe loop on the
//   single slot table read port sets the pace; a two-entry queue decouples intake from it.
// Reset (rst, synchronous): empty table, no flags, window cleared, length 8; results
//   are strobed for one cycle and the receiver cannot stall.
module binary_multi_pattern_matcher_unit
  import bmpm_pkg::*;
#(
  parameter int unsigned MAX_PATTERNS = 64,
  parameter int unsigned HASH_SIZE = 128,
  parameter int unsigned MAX_LEN = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       op,
  input  logic             bit_value,
  input  logic [PAT_W-1:0] pattern_value,
  input  logic             cfg_we,
  input  logic [LEN_W-1:0] cfg_data,
  output logic             done,
  output logic [ID_W-1:0]  pattern_id,
  output logic             none_found,
  output logic             last
);
  cmd_t front_cmd, q_cmd;
  logic take, q_empty, q_full, pop;

  // Hold intake while the queue is full.
  assign busy = q_full;
  assign take = start && !busy;

  bmpm_front #(.MAX_LEN(MAX_LEN)) u_front (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data), .take(take),
    .op(op), .bit_value(bit_value), .pattern_value(pattern_value), .cmd(front_cmd)
  );

  bmpm_fifo u_fifo (
    .clk(clk), .rst(rst), .push(take), .din(front_cmd), .pop(pop),
    .dout(q_cmd), .empty(q_empty), .full(q_full)
  );

  bmpm_back #(.MAX_PATTERNS(MAX_PATTERNS), .HASH_SIZE(HASH_SIZE)) u_back (
    .clk(clk), .rst(rst), .cmd_valid(!q_empty), .cmd(q_cmd), .cmd_pop(pop),
    .pattern_id(pattern_id), .none_found(none_found),
    .last(last), .result_valid(done)
  );
endmodule

>>> hdl/bmpm_front.sv
// Front end: takes transactions, masks patterns, tracks the text window.
module bmpm_front
  import bmpm_pkg::*;
#(
  parameter int unsigned MAX_LEN = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [LEN_W-1:0] cfg_data,
  input  logic             take,
  input  logic [1:0]       op,
  input  logic             bit_value,
  input  logic [PAT_W-1:0] pattern_value,
  output cmd_t             cmd
);
  logic [LEN_W-1:0] pattern_len;
  logic [LEN_W-1:0] eff_len;
  logic [PAT_W-1:0] mask;
  logic [PAT_W-1:0] window_bits;
  logic [PAT_W-1:0] window_next;
  logic [LEN_W-1:0] bits_seen;
  logic [LEN_W-1:0] seen_next;

  always_comb begin
    eff_len = pattern_len;
    if (eff_len == '0) eff_len = LEN_W'(1);
    if (eff_len > LEN_W'(MAX_LEN)) eff_len = LEN_W'(MAX_LEN);
    mask = (eff_len >= LEN_W'(PAT_W)) ? '1 : ((PAT_W'(1) << eff_len) - PAT_W'(1));
    window_next = {window_bits[PAT_W-2:0], bit_value} & mask;
    seen_next = (bits_seen < LEN_W'(MAX_LEN)) ? bits_seen + LEN_W'(1) : bits_seen;
    cmd.op = op_t'(op);
    cmd.lookup = 1'b0;
    case (op_t'(op))
      OP_LOAD: cmd.value = pattern_value & mask;
      OP_BIT: begin
        cmd.value = window_next;
        cmd.lookup = (seen_next >= eff_len);
      end
      default: cmd.value = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_len <= LEN_W'(8);
      window_bits <= '0;
      bits_seen <= '0;
    end else begin
      if (cfg_we) pattern_len <= cfg_data;
      if (take && op_t'(op) == OP_BIT) begin
        window_bits <= window_next;
        bits_seen <= seen_next;
      end else if (take && op_t'(op) == OP_END) begin
        window_bits <= '0;
        bits_seen <= '0;
      end
    end
  end
endmodule

>>> hdl/bmpm_fifo.sv
// Short command queue between the front and back ends.
module bmpm_fifo
  import bmpm_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t din,
  input  logic pop,
  output cmd_t dout,
  output logic empty,
  output logic full
);
  cmd_t mem [2];
  logic wp, rp;
  logic [1:0] cnt;

  assign empty = (cnt == 2'd0);
  assign full = (cnt == 2'd2);
  assign dout = mem[rp];

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= din;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

>>> hdl/bmpm_back.sv
// Back end: hash table insert and lookup, match flags and result sweep.
module bmpm_back
  import bmpm_pkg::*;
#(
  parameter int unsigned MAX_PATTERNS = 64,
  parameter int unsigned HASH_SIZE = 128
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cmd_valid,
  input  cmd_t            cmd,
  output logic            cmd_pop,
  output logic [ID_W-1:0] pattern_id,
  output logic            none_found,
  output logic            last,
  output logic            result_valid
);
  localparam int unsigned HW = (HASH_SIZE > 1) ? $clog2(HASH_SIZE) : 1;
  localparam int unsigned PW = (MAX_PATTERNS > 1) ? $clog2(MAX_PATTERNS) : 1;
  localparam int unsigned CW = HW + 1;

  typedef enum logic [2:0] {S_IDLE, S_READ, S_CHECK, S_STORE, S_SWEEP} state_t;

  state_t state;
  logic [ID_W-1:0] slots [HASH_SIZE];
  logic [PAT_W-1:0] store [MAX_PATTERNS];
  logic [HASH_SIZE-1:0] slot_ok;
  logic [MAX_PATTERNS-1:0] flags;
  logic [ID_W-1:0] pattern_count;
  logic [HW-1:0] pos;
  logic [CW-1:0] probes;
  logic [PAT_W-1:0] key;
  logic is_load;
  logic [ID_W-1:0] slot_q;
  logic [PAT_W-1:0] pat_q;
  logic [PW:0] sweep_i;
  logic any_found;
  logic [ID_W-1:0] rd_id;
  logic [MAX_PATTERNS-1:0] rest;
  logic idle;

  assign idle = (state == S_IDLE);
  assign cmd_pop = idle && cmd_valid;
  assign rd_id = slot_ok[pos] ? slots[pos] : '0;

  always_comb begin
    rest = '0;
    for (int k = 0; k < MAX_PATTERNS; k++)
      rest[k] = flags[k] && (k > int'(sweep_i));
  end

  always_ff @(posedge clk) begin
    slot_q <= rd_id;
    pat_q <= store[PW'(rd_id - ID_W'(1))];
    if (state == S_CHECK && is_load && slot_q == '0)
      store[PW'(pattern_count)] <= key;
    if (state == S_CHECK && is_load && slot_q == '0)
      slots[pos] <= pattern_count + ID_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      slot_ok <= '0;
      flags <= '0;
      pattern_count <= '0;
      result_valid <= 1'b0;
      pattern_id <= '0;
      none_found <= 1'b0;
      last <= 1'b0;
      pos <= '0;
      probes <= '0;
      key <= '0;
      is_load <= 1'b0;
      sweep_i <= '0;
      any_found <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            key <= cmd.value;
            pos <= HW'(cmd.value);
            probes <= '0;
            is_load <= (cmd.op == OP_LOAD);
            sweep_i <= '0;
            any_found <= 1'b0;
            case (cmd.op)
              OP_LOAD:
                if (pattern_count < ID_W'(MAX_PATTERNS)) state <= S_READ;
              OP_BIT:
                if (cmd.lookup) state <= S_READ;
              OP_END: state <= S_SWEEP;
              default: state <= S_IDLE;
            endcase
          end
        end
        S_READ: state <= S_CHECK;
        S_CHECK: begin
          if (slot_q == '0) begin
            if (is_load) begin
              slot_ok[pos] <= 1'b1;
              pattern_count <= pattern_count + ID_W'(1);
            end
            state <= S_IDLE;
          end else if (!is_load && slot_q <= ID_W'(MAX_PATTERNS) && pat_q == key) begin
            flags[PW'(slot_q - ID_W'(1))] <= 1'b1;
            state <= S_IDLE;
          end else if (probes == CW'(HASH_SIZE - 1)) begin
            state <= S_IDLE;
          end else begin
            probes <= probes + CW'(1);
            pos <= pos + HW'(1);
            state <= S_READ;
          end
        end
        S_SWEEP: begin
          if (flags[sweep_i[PW-1:0]]) begin
            result_valid <= 1'b1;
            pattern_id <= ID_W'(sweep_i) + ID_W'(1);
            none_found <= 1'b0;
            last <= (rest == '0);
            any_found <= 1'b1;
            flags[sweep_i[PW-1:0]] <= 1'b0;
          end
          if (sweep_i == (PW+1)'(MAX_PATTERNS - 1)) begin
            if (!any_found && !flags[sweep_i[PW-1:0]]) begin
              result_valid <= 1'b1;
              pattern_id <= '0;
              none_found <= 1'b1;
              last <= 1'b1;
            end
            state <= S_IDLE;
          end else begin
            sweep_i <= sweep_i + (PW+1)'(1);
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

>>> verif/bmpm_checker.sv
// Checker for the binary multi-pattern matcher: predicts match reports and compares them.
module bmpm_checker
  import bmpm_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             busy,
  input  logic [1:0]       op,
  input  logic             bit_value,
  input  logic [PAT_W-1:0] pattern_value,
  input  logic             cfg_we,
  input  logic [LEN_W-1:0] cfg_data,
  input  logic             done,
  input  logic [ID_W-1:0]  pattern_id,
  input  logic             none_found,
  input  logic             last,
  output int               errors,
  output int               pending
);
  localparam int NPAT = 64;
  localparam int NSLOT = 128;

  typedef struct packed {
    logic [ID_W-1:0] id;
    logic            nf;
    logic            lst;
  } match_rpt_t;

  logic [ID_W-1:0]  slot_ids [NSLOT];
  logic [PAT_W-1:0] pat_mem [NPAT];
  logic             hit_flags [NPAT];
  logic [PAT_W-1:0] window;
  int unsigned      seen;
  int unsigned      loaded;
  logic [LEN_W-1:0] plen;
  match_rpt_t       reports_due [$];
  int               err_cnt;

  function automatic int unsigned width_now();
    if (plen == 0) return 1;
    if (plen > 32) return 32;
    return plen;
  endfunction

  function automatic logic [PAT_W-1:0] width_mask();
    int unsigned n;
    n = width_now();
    return (n == 32) ? '1 : ((32'd1 << n) - 32'd1);
  endfunction

  task automatic store_pattern(input logic [PAT_W-1:0] raw);
    logic [PAT_W-1:0] v;
    logic [6:0] pos;
    v = raw & width_mask();
    pos = v[6:0];
    if (loaded >= NPAT) return;
    for (int i = 0; i < NSLOT; i++) begin
      if (slot_ids[pos] == 0) begin
        pat_mem[loaded] = v;
        loaded++;
        slot_ids[pos] = loaded[ID_W-1:0];
        return;
      end
      pos = pos + 7'd1;
    end
  endtask

  task automatic probe_window();
    logic [6:0] pos;
    int unsigned id;
    pos = window[6:0];
    for (int i = 0; i < NSLOT; i++) begin
      id = slot_ids[pos];
      if (id == 0) return;
      if (pat_mem[id-1] == window) begin
        hit_flags[id-1] = 1'b1;
        return;
      end
      pos = pos + 7'd1;
    end
  endtask

  // Emit flagged ids in ascending order, or one none-found report.
  task automatic close_text();
    match_rpt_t r;
    int n;
    n = 0;
    for (int i = 0; i < NPAT; i++) begin
      if (hit_flags[i]) begin
        r.id = ID_W'(i + 1);
        r.nf = 1'b0;
        r.lst = 1'b0;
        reports_due.push_back(r);
        hit_flags[i] = 1'b0;
        n++;
      end
    end
    if (n == 0) begin
      r.id = '0;
      r.nf = 1'b1;
      r.lst = 1'b1;
      reports_due.push_back(r);
    end else begin
      reports_due[$].lst = 1'b1;
    end
    window = '0;
    seen = 0;
  endtask

  always @(posedge clk) begin
    match_rpt_t exp_r;
    if (rst) begin
      foreach (slot_ids[i]) slot_ids[i] = '0;
      foreach (hit_flags[i]) hit_flags[i] = 1'b0;
      foreach (pat_mem[i]) pat_mem[i] = '0;
      window = '0;
      seen = 0;
      loaded = 0;
      plen = 6'd8;
      reports_due.delete();
      err_cnt = 0;
    end else begin
      if (cfg_we) plen = cfg_data;
      if (done) begin
        if (reports_due.size() == 0) begin
          $error("unexpected report: pattern_id %0d none_found %0b last %0b",
                 pattern_id, none_found, last);
          err_cnt++;
        end else begin
          exp_r = reports_due.pop_front();
          if (pattern_id !== exp_r.id) begin
            $error("pattern_id expected %0d actual %0d", exp_r.id, pattern_id);
            err_cnt++;
          end
          if (none_found !== exp_r.nf) begin
            $error("none_found expected %0b actual %0b", exp_r.nf, none_found);
            err_cnt++;
          end
          if (last !== exp_r.lst) begin
            $error("last expected %0b actual %0b", exp_r.lst, last);
            err_cnt++;
          end
        end
      end
      if (start && !busy) begin
        case (op_t'(op))
          OP_LOAD: store_pattern(pattern_value);
          OP_BIT: begin
            window = {window[PAT_W-2:0], bit_value} & width_mask();
            if (seen < 32) seen++;
            if (seen >= width_now()) probe_window();
          end
          OP_END: close_text();
          default: ;
        endcase
      end
    end
    pending <= reports_due.size();
    errors <= err_cnt;
  end
endmodule

>>> verif/binary_multi_pattern_matcher_unit_tb.sv
// Testbench top for the binary multi-pattern matcher: stimulus, watchdog and verdict.
module binary_multi_pattern_matcher_unit_tb;
  import bmpm_pkg::*;

  // Cycles without any transaction or report before the run is declared hung.
  localparam int STALL_LIMIT = 5000;
  // Worst back-end time: a full probe chain or a sweep of every flag.
  localparam int SETTLE = 300;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic [1:0]       op = OP_NONE;
  logic             bit_value = 1'b0;
  logic [PAT_W-1:0] pattern_value = '0;
  logic             cfg_we = 1'b0;
  logic [LEN_W-1:0] cfg_data = '0;
  logic             busy, done, none_found, last;
  logic [ID_W-1:0]  pattern_id;
  int               errors, pending;
  int               stall_cnt = 0;
  bit               gaps_on = 1'b0;
  logic [LEN_W-1:0] cur_len = 6'd8;
  logic [PAT_W-1:0] sent_patterns [$];
  int               phase_items;

  always #10 clk = ~clk;

  binary_multi_pattern_matcher_unit uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op),
    .bit_value(bit_value), .pattern_value(pattern_value),
    .cfg_we(cfg_we), .cfg_data(cfg_data), .done(done),
    .pattern_id(pattern_id), .none_found(none_found), .last(last)
  );

  bmpm_checker chk (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op),
    .bit_value(bit_value), .pattern_value(pattern_value),
    .cfg_we(cfg_we), .cfg_data(cfg_data), .done(done),
    .pattern_id(pattern_id), .none_found(none_found), .last(last),
    .errors(errors), .pending(pending)
  );

  // Kill the run if neither a transaction nor a report shows up for too long.
  always @(posedge clk) begin
    if (!rst) begin
      if ((start && !busy) || done) stall_cnt <= 0;
      else stall_cnt <= stall_cnt + 1;
      if (stall_cnt >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Drive one transaction and hold it until the block takes it. Start stays
  // high across back-to-back transactions; drop it only for an idle burst.
  task automatic issue(input op_t o, input logic b, input logic [PAT_W-1:0] p);
    int gap;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 8);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    op <= o;
    bit_value <= b;
    pattern_value <= p;
    do @(posedge clk); while (busy);
    phase_items++;
  endtask

  // Hold off until every report has come back, then let the back end settle.
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_length(input logic [LEN_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_data <= v;
    cur_len = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic int unsigned width_now();
    if (cur_len == 0) return 1;
    if (cur_len > 32) return 32;
    return cur_len;
  endfunction

  // Stream the low n bits of a word, most significant first.
  task automatic stream_word(input logic [PAT_W-1:0] w, input int unsigned n);
    for (int i = n - 1; i >= 0; i--) issue(OP_BIT, w[i], $urandom);
  endtask

  task automatic load(input logic [PAT_W-1:0] p);
    sent_patterns.push_back(p);
    issue(OP_LOAD, $urandom_range(0, 1), p);
  endtask

  initial begin
    logic [LEN_W-1:0] lens [9] = '{6'd8, 6'd1, 6'd32, 6'd0, 6'd63, 6'd5, 6'd13, 6'd3, 6'd32};
    logic [PAT_W-1:0] w;
    int pick;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: duplicate after truncation, hash collision, empty and short texts.
    load(32'h0000_00A5);
    load(32'hFFFF_FFA5);   // truncates to the same value; only the lower id reports
    load(32'h0000_0025);   // lands on the same home slot, probes past both earlier entries
    load(32'h0000_0000);
    stream_word(32'hA5, 8);
    stream_word(32'h25, 8);
    issue(OP_END, 1'b0, '0);
    issue(OP_NONE, 1'b1, '1);
    issue(OP_END, 1'b1, '1);  // empty text
    stream_word(32'h5, 3);
    issue(OP_END, 1'b0, '0);  // shorter than the length

    // Random phases, one length each; loads run past capacity over the run.
    foreach (lens[k]) begin
      drain();
      set_length(lens[k]);
      gaps_on = (k < 8);
      phase_items = 0;
      repeat (8) begin
        w = $urandom;
        if ($urandom_range(0, 1)) w = w >> $urandom_range(0, 31);
        load(w);
      end
      while (phase_items < 32) begin
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
          repeat ($urandom_range(0, 3)) issue(OP_BIT, $urandom_range(0, 1), $urandom);
          w = sent_patterns[$urandom_range(0, sent_patterns.size() - 1)];
          stream_word(w, width_now());
          if ($urandom_range(0, 1)) issue(OP_END, $urandom_range(0, 1), $urandom);
        end else if (pick < 8) begin
          issue(OP_BIT, $urandom_range(0, 1), $urandom);
        end else if (pick == 8) begin
          issue(OP_END, $urandom_range(0, 1), $urandom);
        end else begin
          issue(OP_NONE, $urandom_range(0, 1), $urandom);
        end
      end
      issue(OP_END, 1'b0, '0);
    end

    drain();
    if (errors == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
